### src/mm_pkg.sv
// Package for the matrix multiplier: widths, codes and the beat and command types.
`timescale 1ns / 1ps

package mm_pkg;

  // Element format: signed Q8.8.
  localparam int DATA_WIDTH  = 16;
  localparam int FRAC_BITS   = 8;
  localparam int MAX_DIM_DEF = 8;

  // Width of a row, column or inner index.
  localparam int IDX_W = 3;
  // Width of a dimension register, which must be able to hold the dimension itself.
  localparam int DIM_W = 4;
  localparam int CFG_INDEX_W = 2;

  // Actions carried on the command channel.
  localparam logic [1:0] ACT_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] ACT_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] ACT_START      = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INNER = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLS  = 2'd2;

  // Beat on the command channel.
  typedef struct packed {
    logic [1:0]                   action;
    logic [IDX_W-1:0]             row_index;
    logic [IDX_W-1:0]             col_index;
    logic signed [DATA_WIDTH-1:0] element_value;
  } mm_in_t;

  // Beat on the result channel.
  typedef struct packed {
    logic [IDX_W-1:0]             out_row;
    logic [IDX_W-1:0]             out_col;
    logic signed [DATA_WIDTH-1:0] out_value;
    logic                         saturated;
    logic                         last;
  } mm_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             wr_left;
    logic             wr_right;
    logic             issue;
    logic             first;
    logic             last_k;
    logic             last_elem;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] k;
  } mm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;
  } mm_stat_t;

endpackage

### src/mm_ctrl.sv
// Controller for the matrix multiplier: dimension registers and the element sequencer.
`timescale 1ns / 1ps

module mm_ctrl #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  logic [1:0]                          cmd_action,
  input  logic [mm_pkg::IDX_W-1:0]            cmd_row,
  input  logic [mm_pkg::IDX_W-1:0]            cmd_col,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mm_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]            cfg_data,
  output mm_pkg::mm_cmd_t                     ctl,
  input  mm_pkg::mm_stat_t                    stat
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  localparam logic [mm_pkg::DIM_W-1:0] DIM_MAX = mm_pkg::DIM_W'(MAX_DIM);
  localparam logic [mm_pkg::DIM_W-1:0] DIM_ONE = mm_pkg::DIM_W'(1);

  logic [1:0]                     state;
  logic [1:0]                     state_next;
  logic [mm_pkg::IDX_W-1:0]       i_cnt;
  logic [mm_pkg::IDX_W-1:0]       i_cnt_next;
  logic [mm_pkg::IDX_W-1:0]       j_cnt;
  logic [mm_pkg::IDX_W-1:0]       j_cnt_next;
  logic [mm_pkg::IDX_W-1:0]       k_cnt;
  logic [mm_pkg::IDX_W-1:0]       k_cnt_next;
  logic [mm_pkg::DIM_W-1:0]       rows_used;
  logic [mm_pkg::DIM_W-1:0]       inner_used;
  logic [mm_pkg::DIM_W-1:0]       cols_used;
  logic [mm_pkg::DIM_W-1:0]       cfg_clamped;
  logic                           accept;
  logic                           in_range;
  logic                           last_i;
  logic                           last_j;
  logic                           last_k;

  // Commands are taken only while no product is in progress.
  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign cfg_ready = 1'b1;

  // A load outside the storage is dropped.
  assign in_range = ({1'b0, cmd_row} < DIM_MAX) && ({1'b0, cmd_col} < DIM_MAX);

  // Written dimensions are clamped to the supported range.
  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = DIM_ONE;
    end else if (cfg_data > DIM_MAX) begin
      cfg_clamped = DIM_MAX;
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used  <= DIM_MAX;
      inner_used <= DIM_MAX;
      cols_used  <= DIM_MAX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mm_pkg::CFG_ROWS:  rows_used  <= cfg_clamped;
        mm_pkg::CFG_INNER: inner_used <= cfg_clamped;
        mm_pkg::CFG_COLS:  cols_used  <= cfg_clamped;
        default: ;
      endcase
    end
  end

  // Position of the current term within the product.
  assign last_i = (({1'b0, i_cnt} + DIM_ONE) == rows_used);
  assign last_j = (({1'b0, j_cnt} + DIM_ONE) == cols_used);
  assign last_k = (({1'b0, k_cnt} + DIM_ONE) == inner_used);

  // Commands to the datapath.
  always_comb begin
    ctl           = '0;
    ctl.wr_left   = accept && (cmd_action == mm_pkg::ACT_LOAD_LEFT) && in_range;
    ctl.wr_right  = accept && (cmd_action == mm_pkg::ACT_LOAD_RIGHT) && in_range;
    ctl.issue     = (state == ST_ISSUE);
    ctl.first     = (k_cnt == '0);
    ctl.last_k    = last_k;
    ctl.last_elem = last_i && last_j;
    ctl.row       = i_cnt;
    ctl.col       = j_cnt;
    ctl.k         = k_cnt;
  end

  // Sequencer: one multiply per cycle over the inner dimension, then wait for
  // the sum to leave the accumulator before the next element starts.
  always_comb begin
    state_next = state;
    i_cnt_next = i_cnt;
    j_cnt_next = j_cnt;
    k_cnt_next = k_cnt;
    unique case (state)
      ST_IDLE: begin
        if (accept && (cmd_action == mm_pkg::ACT_START)) begin
          state_next = ST_ISSUE;
          i_cnt_next = '0;
          j_cnt_next = '0;
          k_cnt_next = '0;
        end
      end
      ST_ISSUE: begin
        if (last_k) begin
          state_next = ST_WAIT;
          k_cnt_next = '0;
        end else begin
          k_cnt_next = k_cnt + 1'b1;
        end
      end
      ST_WAIT: begin
        if (!stat.busy) begin
          if (last_i && last_j) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_ISSUE;
            if (last_j) begin
              j_cnt_next = '0;
              i_cnt_next = i_cnt + 1'b1;
            end else begin
              j_cnt_next = j_cnt + 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i_cnt <= '0;
      j_cnt <= '0;
      k_cnt <= '0;
    end else begin
      state <= state_next;
      i_cnt <= i_cnt_next;
      j_cnt <= j_cnt_next;
      k_cnt <= k_cnt_next;
    end
  end

endmodule

### src/mm_datapath.sv
// Datapath for the matrix multiplier: element memories, multiplier, accumulator, result register.
`timescale 1ns / 1ps

module mm_datapath #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  mm_pkg::mm_in_t                          cmd,
  input  mm_pkg::mm_cmd_t                         ctl,
  output mm_pkg::mm_stat_t                        stat,
  output logic                                    res_valid,
  input  logic                                    res_stall,
  output mm_pkg::mm_out_t                         res
);

  localparam int DW    = mm_pkg::DATA_WIDTH;
  localparam int IW    = mm_pkg::IDX_W;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = 2 * DW;
  localparam int ACC_W = PW + $clog2(MAX_DIM) + 1;
  localparam int LW    = 2 * IW;

  localparam logic [LW-1:0] STRIDE = LW'(MAX_DIM);
  localparam logic signed [ACC_W-1:0] RES_MAX = ACC_W'((64'sd1 <<< (DW - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] RES_MIN = ACC_W'(-(64'sd1 <<< (DW - 1)));

  logic signed [DW-1:0]    left_mem  [DEPTH];
  logic signed [DW-1:0]    right_mem [DEPTH];

  logic [AW-1:0]           wr_addr;
  logic [AW-1:0]           a_addr;
  logic [AW-1:0]           b_addr;

  // Stage 1: registered memory reads.
  logic                    s1_valid;
  logic                    s1_first;
  logic                    s1_last_k;
  logic                    s1_last_elem;
  logic [IW-1:0]           s1_row;
  logic [IW-1:0]           s1_col;
  logic signed [DW-1:0]    a_q;
  logic signed [DW-1:0]    b_q;

  // Stage 2: registered product.
  logic                    s2_valid;
  logic                    s2_first;
  logic                    s2_last_k;
  logic                    s2_last_elem;
  logic [IW-1:0]           s2_row;
  logic [IW-1:0]           s2_col;
  logic signed [PW-1:0]    prod;

  // Accumulator and its finished sum.
  logic signed [ACC_W-1:0] acc;
  logic                    acc_done;
  logic                    acc_last_elem;
  logic [IW-1:0]           acc_row;
  logic [IW-1:0]           acc_col;
  logic signed [ACC_W-1:0] acc_shifted;
  logic signed [DW-1:0]    sat_value;
  logic                    sat_flag;
  logic                    out_free;

  // Row-major addresses into the element stores.
  assign wr_addr = AW'({{IW{1'b0}}, cmd.row_index} * STRIDE + {{IW{1'b0}}, cmd.col_index});
  assign a_addr  = AW'({{IW{1'b0}}, ctl.row} * STRIDE + {{IW{1'b0}}, ctl.k});
  assign b_addr  = AW'({{IW{1'b0}}, ctl.k} * STRIDE + {{IW{1'b0}}, ctl.col});

  // Element stores: one write port for loads, one registered read port each.
  always_ff @(posedge clk) begin
    if (ctl.wr_left) begin
      left_mem[wr_addr] <= cmd.element_value;
    end
    a_q <= left_mem[a_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_right) begin
      right_mem[wr_addr] <= cmd.element_value;
    end
    b_q <= right_mem[b_addr];
  end

  // Tags that follow the read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= ctl.issue;
    end
    s1_first     <= ctl.first;
    s1_last_k    <= ctl.last_k;
    s1_last_elem <= ctl.last_elem;
    s1_row       <= ctl.row;
    s1_col       <= ctl.col;
  end

  // Shared multiplier.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    prod         <= a_q * b_q;
    s2_first     <= s1_first;
    s2_last_k    <= s1_last_k;
    s2_last_elem <= s1_last_elem;
    s2_row       <= s1_row;
    s2_col       <= s1_col;
  end

  // The result register is free when empty or when its beat leaves this cycle.
  assign out_free = !res_valid || !res_stall;

  // Exact accumulation; the sum is held until the result register takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_done <= 1'b0;
    end else if (s2_valid && s2_last_k) begin
      acc_done <= 1'b1;
    end else if (acc_done && out_free) begin
      acc_done <= 1'b0;
    end
    if (s2_valid) begin
      acc           <= s2_first ? ACC_W'(prod) : acc + ACC_W'(prod);
      acc_last_elem <= s2_last_elem;
      acc_row       <= s2_row;
      acc_col       <= s2_col;
    end
  end

  // Drop the fraction bits by flooring, then clip to the element range.
  assign acc_shifted = acc >>> mm_pkg::FRAC_BITS;

  always_comb begin
    if (acc_shifted > RES_MAX) begin
      sat_value = DW'(RES_MAX);
      sat_flag  = 1'b1;
    end else if (acc_shifted < RES_MIN) begin
      sat_value = DW'(RES_MIN);
      sat_flag  = 1'b1;
    end else begin
      sat_value = DW'(acc_shifted);
      sat_flag  = 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (acc_done && out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (acc_done && out_free) begin
      res.out_row   <= acc_row;
      res.out_col   <= acc_col;
      res.out_value <= sat_value;
      res.saturated <= sat_flag;
      res.last      <= acc_last_elem;
    end
  end

  // Terms still in flight or a sum not yet handed over.
  assign stat.busy = s1_valid || s2_valid || acc_done;

endmodule

### src/matrix_multiply.sv
// Top level of the fixed-point matrix multiplier.
//
//   Channel   Handshake               Beat
//   cmd       cmd_valid / cmd_stall   mm_in_t: load left, load right or start
//   res       res_valid / res_stall   mm_out_t: one element of C, row-major
//   cfg       cfg_valid / cfg_ready   cfg_index, cfg_data: dimension registers
//
// A load or an ignored action leaves cmd_stall low. A start holds cmd_stall high
// until the last sum has entered the result register: one multiply per cycle
// through the single shared multiplier, plus the read, multiply and accumulate
// stages and the hand-off of each sum into the result register.
// A stall on res holds the finished sum in the accumulator and delays the next
// element. Reset is synchronous; dimensions reset to MAX_DIM, element stores are
// not cleared.
`timescale 1ns / 1ps

module matrix_multiply #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  mm_pkg::mm_in_t                      cmd,
  output logic                                res_valid,
  input  logic                                res_stall,
  output mm_pkg::mm_out_t                     res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mm_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]            cfg_data
);

  mm_pkg::mm_cmd_t  ctl;
  mm_pkg::mm_stat_t stat;

  // Sequencer and dimension registers.
  mm_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd_action (cmd.action),
    .cmd_row    (cmd.row_index),
    .cmd_col    (cmd.col_index),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ctl        (ctl),
    .stat       (stat)
  );

  // Stores, multiplier, accumulator and result register.
  mm_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctl       (ctl),
    .stat      (stat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

### verif/testbench.sv
// Self-checking testbench for matrix_multiply: element loads, products and dimension registers.
`timescale 1ns / 1ps

module testbench;

  localparam int DIM = mm_pkg::MAX_DIM_DEF;
  localparam int DW = mm_pkg::DATA_WIDTH;
  localparam int IW = mm_pkg::IDX_W;
  localparam int CW = mm_pkg::CFG_INDEX_W;
  localparam int DMW = mm_pkg::DIM_W;
  localparam logic [1:0] ACT_IGNORED = 2'd3;
  localparam logic [CW-1:0] CFG_SPARE = 2'd3;
  localparam longint VAL_MAX = (longint'(1) << (DW - 1)) - 1;
  localparam longint VAL_MIN = -VAL_MAX - 1;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_BEATS = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  mm_pkg::mm_in_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  mm_pkg::mm_out_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CW-1:0] cfg_index = '0;
  logic [DMW-1:0] cfg_data = '0;

  // Shadow copy of both element stores and the dimension registers.
  logic signed [DW-1:0] left_mat [DIM*DIM];
  logic signed [DW-1:0] right_mat [DIM*DIM];
  bit left_written [DIM*DIM];
  bit right_written [DIM*DIM];
  int rows_n = DIM;
  int inner_n = DIM;
  int cols_n = DIM;

  // Elements of C still owed by the block, oldest first.
  mm_pkg::mm_out_t product_queue [$];

  int bad_count = 0;
  int cmd_beats = 0;
  int idle_pct = 0;

  matrix_multiply uut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // A written dimension is forced into 1..DIM.
  function automatic int clamp_dim(logic [DMW-1:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  // Queue every element of C = A x B for the current dimensions, row-major.
  // The sum is exact; the shift floors it, then it is clipped to the Q8.8 range.
  function automatic void queue_product();
    longint acc;
    longint a;
    longint b;
    longint q;
    mm_pkg::mm_out_t e;
    for (int i = 0; i < rows_n; i++) begin
      for (int j = 0; j < cols_n; j++) begin
        acc = 0;
        for (int k = 0; k < inner_n; k++) begin
          a = left_mat[i*DIM + k];
          b = right_mat[k*DIM + j];
          acc += a * b;
        end
        q = acc >>> mm_pkg::FRAC_BITS;
        e.saturated = 1'b0;
        if (q > VAL_MAX) begin
          q = VAL_MAX;
          e.saturated = 1'b1;
        end else if (q < VAL_MIN) begin
          q = VAL_MIN;
          e.saturated = 1'b1;
        end
        e.out_row = IW'(i);
        e.out_col = IW'(j);
        e.out_value = q[DW-1:0];
        e.last = (i == rows_n - 1) && (j == cols_n - 1);
        product_queue.push_back(e);
      end
    end
  endfunction

  // Update the shadow state for one accepted command beat.
  function automatic void track_command(mm_pkg::mm_in_t c);
    int idx;
    idx = int'(c.row_index) * DIM + int'(c.col_index);
    case (c.action)
      mm_pkg::ACT_LOAD_LEFT: begin
        left_mat[idx] = c.element_value;
        left_written[idx] = 1'b1;
      end
      mm_pkg::ACT_LOAD_RIGHT: begin
        right_mat[idx] = c.element_value;
        right_written[idx] = 1'b1;
      end
      mm_pkg::ACT_START: queue_product();
      default: ;
    endcase
  endfunction

  // Mostly small values so that many sums stay in range; some full-range and edge values.
  function automatic logic signed [DW-1:0] rand_element();
    int pick;
    int v;
    logic [31:0] raw;
    pick = $urandom_range(1, 100);
    raw = $urandom;
    if (pick <= 55) begin
      v = int'($urandom_range(0, 2047)) - 1024;
      return v[DW-1:0];
    end
    if (pick <= 85) return raw[DW-1:0];
    case ($urandom_range(0, 4))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return 16'sh0100;
    endcase
  endfunction

  // Sometimes write a dimension in its out-of-range form, which clamps to the same value.
  function automatic logic [DMW-1:0] dim_code(int d);
    if (d == 1 && $urandom_range(0, 5) == 0) return '0;
    if (d == DIM && $urandom_range(0, 2) == 0) return DMW'($urandom_range(DIM + 1, 15));
    return DMW'(d);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    bad_count++;
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // Send one command beat, with an optional idle burst first, and wait for acceptance.
  task automatic send_command(logic [1:0] act, logic [IW-1:0] r, logic [IW-1:0] c,
                              logic signed [DW-1:0] v);
    mm_pkg::mm_in_t beat;
    int gap;
    beat.action = act;
    beat.row_index = r;
    beat.col_index = c;
    beat.element_value = v;
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      gap = $urandom_range(1, 4);
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= beat;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall !== 1'b0);
    track_command(beat);
    cmd_beats++;
  endtask

  // Drop valid and hold off until every owed element has arrived and the block has settled.
  task automatic wait_quiet();
    cmd_valid <= 1'b0;
    while (product_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; valid stays high when another write follows at once.
  task automatic write_reg(logic [CW-1:0] idx, logic [DMW-1:0] data, bit more);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      mm_pkg::CFG_ROWS: rows_n = clamp_dim(data);
      mm_pkg::CFG_INNER: inner_n = clamp_dim(data);
      mm_pkg::CFG_COLS: cols_n = clamp_dim(data);
      default: ;
    endcase
    if (!more) cfg_valid <= 1'b0;
  endtask

  task automatic set_dims(int r, int i, int c);
    wait_quiet();
    write_reg(mm_pkg::CFG_ROWS, dim_code(r), 1'b1);
    write_reg(mm_pkg::CFG_INNER, dim_code(i), 1'b1);
    write_reg(mm_pkg::CFG_COLS, dim_code(c), 1'b0);
  endtask

  // An ignored action, or a load anywhere in either store.
  task automatic maybe_noise(int pct);
    if (pct != 0 && $urandom_range(1, 100) <= pct) begin
      case ($urandom_range(0, 2))
        0: send_command(ACT_IGNORED, IW'($urandom_range(0, 7)),
                        IW'($urandom_range(0, 7)), rand_element());
        1: send_command(mm_pkg::ACT_LOAD_LEFT, IW'($urandom_range(0, 7)),
                        IW'($urandom_range(0, 7)), rand_element());
        default: send_command(mm_pkg::ACT_LOAD_RIGHT, IW'($urandom_range(0, 7)),
                              IW'($urandom_range(0, 7)), rand_element());
      endcase
    end
  endtask

  // Load every entry the next product reads that has never been loaded.
  task automatic load_needed(int noise);
    for (int i = 0; i < rows_n; i++) begin
      for (int k = 0; k < inner_n; k++) begin
        if (!left_written[i*DIM + k]) begin
          maybe_noise(noise);
          send_command(mm_pkg::ACT_LOAD_LEFT, IW'(i), IW'(k), rand_element());
        end
      end
    end
    for (int k = 0; k < inner_n; k++) begin
      for (int j = 0; j < cols_n; j++) begin
        if (!right_written[k*DIM + j]) begin
          maybe_noise(noise);
          send_command(mm_pkg::ACT_LOAD_RIGHT, IW'(k), IW'(j), rand_element());
        end
      end
    end
  endtask

  // Overwrite random entries inside the active region.
  task automatic touch_entries(int n);
    repeat (n) begin
      if ($urandom_range(0, 1) == 0)
        send_command(mm_pkg::ACT_LOAD_LEFT, IW'($urandom_range(0, rows_n - 1)),
                     IW'($urandom_range(0, inner_n - 1)), rand_element());
      else
        send_command(mm_pkg::ACT_LOAD_RIGHT, IW'($urandom_range(0, inner_n - 1)),
                     IW'($urandom_range(0, cols_n - 1)), rand_element());
    end
  endtask

  // Single-element products: saturation both ways, a negative result of one LSB,
  // ignored action, loads outside the active region, and a pause until all results arrive.
  task automatic test_corner_values();
    set_dims(1, 1, 1);
    send_command(mm_pkg::ACT_LOAD_LEFT, 3'd0, 3'd0, 16'sh7FFF);
    send_command(mm_pkg::ACT_LOAD_RIGHT, 3'd0, 3'd0, 16'sh7FFF);
    send_command(mm_pkg::ACT_START, 3'd0, 3'd0, 16'sh0000);
    send_command(mm_pkg::ACT_LOAD_RIGHT, 3'd0, 3'd0, 16'sh8000);
    send_command(mm_pkg::ACT_START, 3'd0, 3'd0, 16'sh0000);
    send_command(mm_pkg::ACT_LOAD_LEFT, 3'd0, 3'd0, 16'sh8000);
    send_command(mm_pkg::ACT_START, 3'd0, 3'd0, 16'sh0000);
    send_command(mm_pkg::ACT_LOAD_LEFT, 3'd0, 3'd0, 16'sh0100);
    send_command(mm_pkg::ACT_LOAD_RIGHT, 3'd0, 3'd0, 16'shFFFF);
    send_command(mm_pkg::ACT_START, 3'd7, 3'd7, 16'shFFFF);
    send_command(ACT_IGNORED, 3'd7, 3'd7, 16'shFFFF);
    send_command(mm_pkg::ACT_LOAD_LEFT, 3'd7, 3'd7, 16'sh5A5A);
    send_command(mm_pkg::ACT_LOAD_RIGHT, 3'd7, 3'd7, 16'shA5A5);
    send_command(mm_pkg::ACT_START, 3'd0, 3'd0, 16'sh0000);
    wait_quiet();
    send_command(mm_pkg::ACT_LOAD_LEFT, 3'd0, 3'd0, 16'sh0000);
    send_command(mm_pkg::ACT_START, 3'd0, 3'd0, 16'sh0000);
  endtask

  // Out-of-range register values clamp; a write to the spare index changes nothing.
  task automatic test_dim_clamp();
    wait_quiet();
    write_reg(mm_pkg::CFG_ROWS, 4'd0, 1'b1);
    write_reg(mm_pkg::CFG_INNER, 4'd15, 1'b1);
    write_reg(mm_pkg::CFG_COLS, 4'd0, 1'b1);
    write_reg(CFG_SPARE, 4'd5, 1'b0);
    load_needed(0);
    send_command(mm_pkg::ACT_START, 3'd0, 3'd0, 16'sh0000);
    wait_quiet();
    write_reg(mm_pkg::CFG_ROWS, 4'd9, 1'b1);
    write_reg(mm_pkg::CFG_INNER, 4'd1, 1'b1);
    write_reg(mm_pkg::CFG_COLS, 4'd12, 1'b0);
    load_needed(0);
    send_command(mm_pkg::ACT_START, 3'd0, 3'd0, 16'sh0000);
  endtask

  // Load-then-start sequences with random shapes, mostly small, plus noise beats.
  task automatic test_random_products();
    int stop_at;
    int r;
    int i;
    int c;
    stop_at = cmd_beats + RANDOM_BEATS;
    while (cmd_beats < stop_at) begin
      case ($urandom_range(0, 3))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 35;
      endcase
      // Keeping the shape lets the next loads queue up behind a running product.
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 7) == 0) begin
          r = $urandom_range(1, DIM);
          i = $urandom_range(1, DIM);
          c = $urandom_range(1, DIM);
        end else begin
          r = $urandom_range(1, 3);
          i = $urandom_range(1, 3);
          c = $urandom_range(1, 3);
        end
        set_dims(r, i, c);
      end
      load_needed(12);
      touch_entries($urandom_range(0, 4));
      maybe_noise(20);
      send_command(mm_pkg::ACT_START, IW'($urandom_range(0, 7)), IW'($urandom_range(0, 7)),
                   rand_element());
      if ($urandom_range(0, 3) == 0)
        send_command(mm_pkg::ACT_START, 3'd0, 3'd0, 16'sh0000);
    end
  endtask

  // Largest shape, with no idling on either side.
  task automatic test_full_size();
    idle_pct = 0;
    set_dims(DIM, DIM, DIM);
    load_needed(0);
    touch_entries(2);
    send_command(mm_pkg::ACT_START, 3'd0, 3'd0, 16'sh0000);
    send_command(mm_pkg::ACT_START, 3'd0, 3'd0, 16'sh0000);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 20;
    test_corner_values();
    test_dim_clamp();
    test_random_products();
    test_full_size();
    cmd_valid <= 1'b0;
    while (product_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Random stall bursts on the result side.
  initial begin : result_stalls
    int burst;
    forever begin
      @(posedge clk);
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        burst = $urandom_range(1, 4);
        res_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result beat with the oldest owed element.
  always @(posedge clk) begin : check_results
    mm_pkg::mm_out_t want;
    if (!rst && res_valid === 1'b1 && res_stall == 1'b0) begin
      if (product_queue.size() == 0) begin
        report_mismatch("result beat with nothing owed, out_value", int'(res.out_value), 0);
      end else begin
        want = product_queue.pop_front();
        if (res.out_row !== want.out_row)
          report_mismatch("out_row", int'(res.out_row), int'(want.out_row));
        if (res.out_col !== want.out_col)
          report_mismatch("out_col", int'(res.out_col), int'(want.out_col));
        if (res.out_value !== want.out_value)
          report_mismatch("out_value", int'(res.out_value), int'(want.out_value));
        if (res.saturated !== want.saturated)
          report_mismatch("saturated", int'(res.saturated), int'(want.saturated));
        if (res.last !== want.last)
          report_mismatch("last", int'(res.last), int'(want.last));
      end
    end
  end

  // Hard stop if the block hangs.
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
